// ===== hw/rtl/wdq_pkg.sv =====
// Shared types and constants for the weighted deque.
`timescale 1ns / 1ps
`default_nettype none

package wdq_pkg;

  localparam int unsigned WEIGHT_W = 8;
  localparam int unsigned SUM_W    = 12;
  localparam int unsigned OP_W     = 3;

  localparam logic [SUM_W-1:0] LIMIT_RESET = 12'd11;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5,
    OP_CLEAR      = 3'd6,
    OP_STATUS     = 3'd7
  } op_e;

  localparam logic [1:0] LEVEL_STARVING = 2'd0;
  localparam logic [1:0] LEVEL_NOT_FULL = 2'd1;
  localparam logic [1:0] LEVEL_FULL     = 2'd2;

  // Register indexes on the configuration port.
  localparam logic REG_WEIGHT_LIMIT = 1'b0;

endpackage

`default_nettype wire

// ===== hw/rtl/wdq_ring.sv =====
// Ring store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module wdq_ring #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned AW     = 4,
  parameter int unsigned DATA_W = 8
) (
  input  wire              clk_i,
  input  wire              we_i,
  input  wire [AW-1:0]     waddr_i,
  input  wire [DATA_W-1:0] wdata_i,
  input  wire              re_i,
  input  wire [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/weighted_deque_top.sv =====
// Weighted deque top level: request decode, ring pointers, weight sum, APB register.
`timescale 1ns / 1ps
`default_nettype none

// A request is taken in every clock cycle: busy_o stays low and start_i may be held
// high continuously. Each request produces exactly one result: the request is
// registered into the s1 stage, then into the result registers that drive done_o.
// The result is on the ports for a single cycle and the receiver cannot stall it.
// Pointers and entry count move at the request edge; the ring store read is
// registered, so the weight sum is settled in the following cycle and is forwarded
// to the next request's limit check. No clearing pass is needed after reset.
// weight_limit (reset 11) lives at byte address 0 and may be written only while idle.
module weighted_deque_top import wdq_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  output logic                busy_o,
  input  wire [OP_W-1:0]      op_i,
  input  wire [WEIGHT_W-1:0]  weight_i,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire [2:0]           paddr,
  input  wire [31:0]          pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output logic                done_o,
  output logic                ok_o,
  output logic [WEIGHT_W-1:0] data_o,
  output logic [1:0]          level_o,
  output logic [SUM_W-1:0]    weight_sum_o,
  output logic [CW-1:0]       entries_o
);

  localparam int unsigned SW = AW + 1;

  // ---------------------------------------------------------------- config
  logic [SUM_W-1:0] limit_q;
  logic             cfg_we;

  assign pready = 1'b1;
  // Register index comes from paddr[2]; byte-lane bits are ignored.
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_WEIGHT_LIMIT);
  assign prdata = (paddr[2] == REG_WEIGHT_LIMIT) ? {{(32-SUM_W){1'b0}}, limit_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit_q <= pwdata[SUM_W-1:0];
    end
  end

  // ---------------------------------------------------------------- state
  logic [AW-1:0]       front_q, front_d;
  logic [CW-1:0]       count_q, count_d;
  logic [SUM_W-1:0]    sum_q, sum_next, sum_cur;

  logic                s1_valid_q;
  op_e                 s1_op_q;
  logic                s1_ok_q;
  logic [WEIGHT_W-1:0] s1_w_q;
  logic [CW-1:0]       s1_count_q;

  logic [WEIGHT_W-1:0] rdata;

  op_e                 op;
  logic                accept;
  logic                is_push, not_empty, push_ok, req_ok;
  logic [CW-1:0]       off;
  logic [SW-1:0]       back_sum;
  logic [AW-1:0]       back_addr, front_dec, front_inc;
  logic [SUM_W:0]      push_total;
  logic                ring_we, ring_re;
  logic [AW-1:0]       ring_waddr, ring_raddr;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign op     = op_e'(op_i);

  assign is_push   = (op == OP_PUSH_FRONT) || (op == OP_PUSH_BACK);
  assign not_empty = (count_q != '0);

  // Back slot: front + count for a push, front + count - 1 for a read; always < 2*DEPTH.
  assign off       = is_push ? count_q : count_q - CW'(1);
  assign back_sum  = SW'(front_q) + SW'(off);
  assign back_addr = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
  assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
  assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);

  // Sum after the request still in flight, so back-to-back pushes see a pop's effect.
  always_comb begin
    sum_next = sum_q;
    case (s1_op_q)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (s1_ok_q) sum_next = sum_q + SUM_W'(s1_w_q);
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (s1_ok_q) sum_next = sum_q - SUM_W'(rdata);
      end
      OP_CLEAR: sum_next = '0;
      default:  sum_next = sum_q;
    endcase
  end

  assign sum_cur    = s1_valid_q ? sum_next : sum_q;
  assign push_total = {1'b0, sum_cur} + (SUM_W + 1)'(weight_i);
  assign push_ok    = (count_q < CW'(DEPTH)) && (push_total <= {1'b0, limit_q});

  always_comb begin
    front_d    = front_q;
    count_d    = count_q;
    req_ok     = 1'b1;
    ring_we    = 1'b0;
    ring_re    = 1'b0;
    ring_waddr = back_addr;
    ring_raddr = back_addr;
    unique case (op)
      OP_PUSH_FRONT: begin
        req_ok     = push_ok;
        ring_we    = accept && push_ok;
        ring_waddr = front_dec;
        if (push_ok) begin
          front_d = front_dec;
          count_d = count_q + CW'(1);
        end
      end
      OP_PUSH_BACK: begin
        req_ok  = push_ok;
        ring_we = accept && push_ok;
        if (push_ok) count_d = count_q + CW'(1);
      end
      OP_POP_FRONT: begin
        req_ok     = not_empty;
        ring_re    = accept && not_empty;
        ring_raddr = front_q;
        if (not_empty) begin
          front_d = front_inc;
          count_d = count_q - CW'(1);
        end
      end
      OP_POP_BACK: begin
        req_ok  = not_empty;
        ring_re = accept && not_empty;
        if (not_empty) count_d = count_q - CW'(1);
      end
      OP_PEEK_FRONT: begin
        req_ok     = not_empty;
        ring_re    = accept && not_empty;
        ring_raddr = front_q;
      end
      OP_PEEK_BACK: begin
        req_ok  = not_empty;
        ring_re = accept && not_empty;
      end
      OP_CLEAR: begin
        front_d = '0;
        count_d = '0;
      end
      OP_STATUS: req_ok = 1'b1;
      default:   req_ok = 1'b1;
    endcase
  end

  wdq_ring #(
    .DEPTH  (DEPTH),
    .AW     (AW),
    .DATA_W (WEIGHT_W)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (weight_i),
    .re_i    (ring_re),
    .raddr_i (ring_raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q    <= '0;
      count_q    <= '0;
      sum_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_op_q    <= OP_STATUS;
    end else begin
      if (s1_valid_q) sum_q <= sum_next;
      s1_valid_q <= accept;
      if (accept) begin
        front_q <= front_d;
        count_q <= count_d;
        s1_op_q <= op;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ok_q    <= req_ok;
      s1_w_q     <= weight_i;
      s1_count_q <= count_d;
    end
  end

  // ---------------------------------------------------------------- result
  logic                done_q;
  logic                ok_q;
  logic [WEIGHT_W-1:0] data_q;
  logic [1:0]          level_q;
  logic [SUM_W-1:0]    wsum_q;
  logic [CW-1:0]       entries_q;
  logic                s1_is_read;
  logic [1:0]          level_d;

  assign s1_is_read = (s1_op_q == OP_POP_FRONT) || (s1_op_q == OP_POP_BACK) ||
                      (s1_op_q == OP_PEEK_FRONT) || (s1_op_q == OP_PEEK_BACK);

  // Starving wins over full when the limit is zero.
  assign level_d = (sum_next == '0)     ? LEVEL_STARVING :
                   (sum_next == limit_q) ? LEVEL_FULL : LEVEL_NOT_FULL;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      ok_q      <= s1_ok_q;
      data_q    <= (s1_ok_q && s1_is_read) ? rdata : '0;
      level_q   <= level_d;
      wsum_q    <= sum_next;
      entries_q <= s1_count_q;
    end
  end

  assign done_o       = done_q;
  assign ok_o         = ok_q;
  assign data_o       = data_q;
  assign level_o      = level_q;
  assign weight_sum_o = wsum_q;
  assign entries_o    = entries_q;

  // ---------------------------------------------------------------- checks
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 done_o)
    else $error("request without result two cycles later");

  a_no_stray_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(s1_valid_q))
    else $error("result strobe without request in flight");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (entries_o <= CW'(DEPTH)))
    else $error("entry count beyond ring depth");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !ok_o) |-> (data_o == '0))
    else $error("refused request returned data");

endmodule

`default_nettype wire

// ===== bench/weighted_deque_top_tb.sv =====
// Self-checking bench for the weighted deque: directed request table, then random request mix.
`timescale 1ns / 1ps

module weighted_deque_top_tb;
  import wdq_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  localparam logic [2:0] LIMIT_ADDR = {REG_WEIGHT_LIMIT, 2'b00};

  typedef struct packed {
    logic                ok;
    logic [WEIGHT_W-1:0] data;
    logic [1:0]          level;
    logic [SUM_W-1:0]    weight_sum;
    logic [CW-1:0]       entries;
  } deque_result_t;

  typedef struct {
    op_e                 op;
    logic [WEIGHT_W-1:0] weight;
    bit                  fixed;
    deque_result_t       want;
  } table_row_t;

  typedef struct {
    int unsigned limit;
    int unsigned count;
    int unsigned push_pct;
    bit          idles;
  } phase_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [OP_W-1:0]     op_i;
  logic [WEIGHT_W-1:0] weight_i;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  logic                done_o;
  logic                ok_o;
  logic [WEIGHT_W-1:0] data_o;
  logic [1:0]          level_o;
  logic [SUM_W-1:0]    weight_sum_o;
  logic [CW-1:0]       entries_o;

  weighted_deque_top #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .op_i         (op_i),
    .weight_i     (weight_i),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .done_o       (done_o),
    .ok_o         (ok_o),
    .data_o       (data_o),
    .level_o      (level_o),
    .weight_sum_o (weight_sum_o),
    .entries_o    (entries_o)
  );

  // Shadow copy of the deque, updated as each request is taken.
  logic [WEIGHT_W-1:0] mirror_ring [DEPTH];
  logic [AW-1:0]       mirror_front;
  logic [CW-1:0]       mirror_count;
  logic [SUM_W-1:0]    mirror_sum;
  logic [SUM_W-1:0]    mirror_limit;

  deque_result_t expected_results [$];

  int unsigned mismatch_count;
  int unsigned requests_sent;
  int unsigned results_seen;
  int unsigned refused_count;
  int unsigned limit_writes;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic log_mismatch(string msg);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      log_mismatch($sformatf("result %0d field %s got 0x%0h want 0x%0h",
                             results_seen, name, got, want));
    end
  endtask

  function automatic deque_result_t predict_request(op_e op, logic [WEIGHT_W-1:0] w);
    deque_result_t r;
    logic [AW-1:0] slot;
    r = '0;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (mirror_count < DEPTH && ({1'b0, mirror_sum} + w) <= {1'b0, mirror_limit}) begin
          if (op == OP_PUSH_FRONT) begin
            mirror_front = mirror_front - 1'b1;
            slot = mirror_front;
          end else begin
            slot = AW'(mirror_front + mirror_count);
          end
          mirror_ring[slot] = w;
          mirror_count = mirror_count + 1'b1;
          mirror_sum = mirror_sum + w;
          r.ok = 1'b1;
        end
      end
      OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
        if (mirror_count != 0) begin
          if (op == OP_POP_FRONT || op == OP_PEEK_FRONT) slot = mirror_front;
          else slot = AW'(mirror_front + mirror_count - 1'b1);
          r.data = mirror_ring[slot];
          if (op == OP_POP_FRONT || op == OP_POP_BACK) begin
            if (op == OP_POP_FRONT) mirror_front = mirror_front + 1'b1;
            mirror_count = mirror_count - 1'b1;
            mirror_sum = mirror_sum - r.data;
          end
          r.ok = 1'b1;
        end
      end
      OP_CLEAR: begin
        mirror_front = '0;
        mirror_count = '0;
        mirror_sum = '0;
        r.ok = 1'b1;
      end
      default: r.ok = 1'b1;
    endcase
    // starving wins over full when the limit is zero
    if (mirror_sum == 0) r.level = LEVEL_STARVING;
    else if (mirror_sum == mirror_limit) r.level = LEVEL_FULL;
    else r.level = LEVEL_NOT_FULL;
    r.weight_sum = mirror_sum;
    r.entries = mirror_count;
    return r;
  endfunction

  // Hold the request until taken; a fixed row queues its typed-in result instead.
  task automatic issue(op_e op, logic [WEIGHT_W-1:0] w, bit fixed, deque_result_t want);
    deque_result_t pred;
    start_i  <= 1'b1;
    op_i     <= op;
    weight_i <= w;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    pred = predict_request(op, w);
    if (!pred.ok) refused_count++;
    expected_results = {expected_results, (fixed ? want : pred)};
    requests_sent++;
  endtask

  task automatic idle_sender(int unsigned cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_limit_readback();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= LIMIT_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    if (prdata !== 32'(mirror_limit)) begin
      log_mismatch($sformatf("weight_limit read 0x%0h want 0x%0h", prdata, mirror_limit));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Only called with the deque idle; the read request follows straight on.
  task automatic write_limit(logic [SUM_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LIMIT_ADDR;
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    mirror_limit = value;
    limit_writes++;
    check_limit_readback();
  endtask

  always @(posedge clk_i) begin : result_check
    deque_result_t want;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        log_mismatch($sformatf("result %0d with no request outstanding", results_seen));
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        compare_field("ok", 32'(ok_o), 32'(want.ok));
        compare_field("data", 32'(data_o), 32'(want.data));
        compare_field("level", 32'(level_o), 32'(want.level));
        compare_field("weight_sum", 32'(weight_sum_o), 32'(want.weight_sum));
        compare_field("entries", 32'(entries_o), 32'(want.entries));
      end
    end
  end

  // Limit is 11 after reset.
  table_row_t directed [22] = '{
    '{OP_POP_FRONT,  8'h00, 1'b1, '{1'b0, 8'd0,  LEVEL_STARVING, 12'd0,  5'd0}},
    '{OP_POP_BACK,   8'hFF, 1'b1, '{1'b0, 8'd0,  LEVEL_STARVING, 12'd0,  5'd0}},
    '{OP_PEEK_FRONT, 8'h00, 1'b1, '{1'b0, 8'd0,  LEVEL_STARVING, 12'd0,  5'd0}},
    '{OP_PEEK_BACK,  8'h00, 1'b1, '{1'b0, 8'd0,  LEVEL_STARVING, 12'd0,  5'd0}},
    '{OP_STATUS,     8'hA5, 1'b1, '{1'b1, 8'd0,  LEVEL_STARVING, 12'd0,  5'd0}},
    '{OP_PUSH_BACK,  8'hFF, 1'b1, '{1'b0, 8'd0,  LEVEL_STARVING, 12'd0,  5'd0}},
    '{OP_PUSH_FRONT, 8'h00, 1'b1, '{1'b1, 8'd0,  LEVEL_STARVING, 12'd0,  5'd1}},
    '{OP_PUSH_BACK,  8'd11, 1'b1, '{1'b1, 8'd0,  LEVEL_FULL,     12'd11, 5'd2}},
    '{OP_PUSH_FRONT, 8'd1,  1'b1, '{1'b0, 8'd0,  LEVEL_FULL,     12'd11, 5'd2}},
    '{OP_PEEK_BACK,  8'h00, 1'b1, '{1'b1, 8'd11, LEVEL_FULL,     12'd11, 5'd2}},
    '{OP_PEEK_FRONT, 8'h00, 1'b1, '{1'b1, 8'd0,  LEVEL_FULL,     12'd11, 5'd2}},
    '{OP_POP_BACK,   8'h00, 1'b1, '{1'b1, 8'd11, LEVEL_STARVING, 12'd0,  5'd1}},
    '{OP_PUSH_BACK,  8'd5,  1'b0, '0},
    '{OP_PUSH_FRONT, 8'd6,  1'b0, '0},
    '{OP_PUSH_BACK,  8'd0,  1'b0, '0},
    '{OP_POP_FRONT,  8'h00, 1'b0, '0},
    '{OP_PEEK_BACK,  8'h00, 1'b0, '0},
    '{OP_POP_BACK,   8'h00, 1'b0, '0},
    '{OP_POP_BACK,   8'h00, 1'b0, '0},
    '{OP_CLEAR,      8'h3C, 1'b1, '{1'b1, 8'd0,  LEVEL_STARVING, 12'd0,  5'd0}},
    '{OP_POP_FRONT,  8'h5A, 1'b1, '{1'b0, 8'd0,  LEVEL_STARVING, 12'd0,  5'd0}},
    '{OP_PUSH_BACK,  8'h80, 1'b1, '{1'b0, 8'd0,  LEVEL_STARVING, 12'd0,  5'd0}}
  };

  initial begin : stimulus
    phase_t        plan [9];
    op_e           op;
    logic [7:0]    w;
    int unsigned   pick;
    int unsigned   room;

    start_i  <= 1'b0;
    op_i     <= OP_STATUS;
    weight_i <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= LIMIT_ADDR;
    pwdata   <= '0;
    rst_ni   <= 1'b0;

    mirror_front = '0;
    mirror_count = '0;
    mirror_sum   = '0;
    mirror_limit = LIMIT_RESET;
    foreach (mirror_ring[i]) mirror_ring[i] = '0;

    // limit 3 right after a push-heavy phase leaves the sum above the limit
    plan[0] = '{4095, 250, 70, 1'b1};
    plan[1] = '{3,    150, 40, 1'b1};
    plan[2] = '{0,    100, 35, 1'b1};
    plan[3] = '{4080, 250, 75, 1'b0};
    plan[4] = '{$urandom_range(4095), 200, 55, 1'b1};
    plan[5] = '{255,  200, 60, 1'b1};
    plan[6] = '{40,   200, 55, 1'b1};
    plan[7] = '{11,   150, 50, 1'b1};
    plan[8] = '{$urandom_range(300), 200, 50, 1'b1};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_limit_readback();

    foreach (directed[i]) begin
      issue(directed[i].op, directed[i].weight, directed[i].fixed, directed[i].want);
    end

    foreach (plan[p]) begin
      drain_results();
      write_limit(plan[p].limit[SUM_W-1:0]);
      for (int unsigned n = 0; n < plan[p].count; n++) begin
        if ($urandom_range(99) < plan[p].push_pct) begin
          op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        end else begin
          pick = $urandom_range(99);
          if (pick < 55) op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
          else if (pick < 80) op = $urandom_range(1) ? OP_PEEK_BACK : OP_PEEK_FRONT;
          else if (pick < 88) op = OP_CLEAR;
          else op = OP_STATUS;
        end
        // bias weights toward the edges and toward filling the limit exactly
        room = (mirror_limit >= mirror_sum) ? 32'(mirror_limit - mirror_sum) : 0;
        pick = $urandom_range(99);
        if (pick < 15) w = 8'h00;
        else if (pick < 30) w = 8'hFF;
        else if (pick < 50 && room <= 255) w = room[7:0];
        else if (pick < 70) w = 8'($urandom_range(1, 15));
        else w = 8'($urandom);
        issue(op, w, 1'b0, '0);
        // in phases with idles, each further idle cycle comes with odds 27 in 100
        while (plan[p].idles && $urandom_range(99) < 27) idle_sender(1);
        if ($urandom_range(199) == 0) drain_results();
      end
    end

    drain_results();
    repeat (6) @(posedge clk_i);
    $display("Covered %0d requests (%0d refused) across %0d weight_limit writes;",
             requests_sent, refused_count, limit_writes);
    $display("checked %0d results, %0d mismatches.", results_seen, mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
